// ===== design/snp_pkg.sv =====
// Shared constants for the singular value soft threshold block.
`default_nettype none
package snp_pkg;
  localparam int DW = 32;
  localparam int SW = 31;
  localparam logic [SW-1:0] THR_RESET = 31'd65536;
  localparam logic [30:0] ONE30 = 31'h4000_0000;
endpackage
`default_nettype wire

// ===== design/snp_in_if.sv =====
// Input channel carrying one 2x3 matrix per beat.
`default_nettype none
interface snp_in_if;
  logic valid;
  logic ready;
  logic signed [snp_pkg::DW-1:0] q_r0c0;
  logic signed [snp_pkg::DW-1:0] q_r0c1;
  logic signed [snp_pkg::DW-1:0] q_r0c2;
  logic signed [snp_pkg::DW-1:0] q_r1c0;
  logic signed [snp_pkg::DW-1:0] q_r1c1;
  logic signed [snp_pkg::DW-1:0] q_r1c2;
  modport source (output valid, q_r0c0, q_r0c1, q_r0c2, q_r1c0, q_r1c1, q_r1c2,
                  input ready);
  modport sink (input valid, q_r0c0, q_r0c1, q_r0c2, q_r1c0, q_r1c1, q_r1c2,
                output ready);
endinterface
`default_nettype wire

// ===== design/snp_out_if.sv =====
// Output channel carrying the rebuilt matrix and shrunk top singular value per beat.
`default_nettype none
interface snp_out_if;
  logic valid;
  logic ready;
  logic signed [snp_pkg::DW-1:0] m_r0c0;
  logic signed [snp_pkg::DW-1:0] m_r0c1;
  logic signed [snp_pkg::DW-1:0] m_r0c2;
  logic signed [snp_pkg::DW-1:0] m_r1c0;
  logic signed [snp_pkg::DW-1:0] m_r1c1;
  logic signed [snp_pkg::DW-1:0] m_r1c2;
  logic [snp_pkg::SW-1:0] top_sigma;
  logic degenerate;
  modport source (output valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                  top_sigma, degenerate, input ready);
  modport sink (input valid, m_r0c0, m_r0c1, m_r0c2, m_r1c0, m_r1c1, m_r1c2,
                top_sigma, degenerate, output ready);
endinterface
`default_nettype wire

// ===== design/spectral_norm_prox_2x3.sv =====
// Pipelined singular value soft threshold of a 2x3 matrix.
//
//   channel   | direction | content
//   src       | in        | matrix A, six signed Q16.16 entries
//   dst       | out       | rebuilt matrix, shrunk top sigma, degenerate flag
//   cfg_we    | in        | threshold write, unsigned Q15.16
//
// One beat enters per cycle unless held. The depth is set by the 64-step square root of
// the eigenvalue spread, the 34-step square roots of the eigenvalues and the 30-step
// quotient units. The whole pipeline advances together and holds when the output
// stage is full and not taken. Reset clears the valid bits and sets the threshold to 1.0.
`default_nettype none
module spectral_norm_prox_2x3 (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [snp_pkg::SW-1:0]   cfg_wdata,
  snp_in_if.sink                        src,
  snp_out_if.source                     dst
);

  localparam int S_IN   = 0;
  localparam int S_PROD = 1;
  localparam int S_SUM  = 2;
  localparam int S_ABS  = 3;
  localparam int S_PART = 4;
  localparam int S_SQ   = 5;
  localparam int S_D4   = 6;
  localparam int S_H0   = 7;
  localparam int NH     = 64;
  localparam int S_L    = S_H0 + NH;
  localparam int S_N0   = S_L + 1;
  localparam int NN     = 34;
  localparam int S_SHR  = S_N0 + NN;
  localparam int S_TI   = S_SHR + 1;
  localparam int S_T0   = S_TI + 1;
  localparam int NQ     = 30;
  localparam int S_MW   = S_T0 + NQ;
  localparam int S_W    = S_MW + 1;
  localparam int S_MM   = S_W + 1;
  localparam int S_OUT  = S_MM + 1;
  localparam int NST    = S_OUT + 1;

  typedef struct packed {
    logic [127:0] x;
    logic [127:0] res;
  } sq_t;

  typedef struct packed {
    logic [34:0] rem;
    logic [29:0] q;
  } dv_t;

  typedef struct {
    logic signed [snp_pkg::DW-1:0] a [6];
    logic signed [63:0] pr [9];
    logic [63:0] p;
    logic [63:0] q;
    logic signed [65:0] r;
    logic [63:0] emag;
    logic [63:0] rmag;
    logic e_neg;
    logic r_neg;
    logic [64:0] tr;
    logic [63:0] pe [3];
    logic [63:0] rp [3];
    logic [127:0] e2;
    logic [127:0] r2;
    logic [127:0] x;
    logic [127:0] res;
    logic [63:0] h;
    logic [67:0] x1;
    logic [67:0] res1;
    logic [67:0] x2;
    logic [67:0] res2;
    logic [7:0] nz;
    logic [5:0] k;
    logic [30:0] hs;
    logic [31:0] es;
    logic [31:0] rs;
    logic fc;
    logic fs;
    logic [32:0] remc;
    logic [32:0] rems;
    logic [29:0] qc;
    logic [29:0] qs;
    logic signed [32:0] p00;
    logic signed [32:0] p01;
    logic signed [32:0] p11;
    logic [33:0] s1;
    logic [33:0] s2;
    logic [33:0] n1;
    logic [33:0] n2;
    logic degen;
    logic [30:0] ts;
    logic z1;
    logic z2;
    logic f1;
    logic f2;
    logic [34:0] rem1;
    logic [34:0] rem2;
    logic [29:0] q1;
    logic [29:0] q2;
    logic signed [63:0] base;
    logic signed [65:0] pw [3];
    logic signed [31:0] w00;
    logic signed [31:0] w01;
    logic signed [31:0] w11;
    logic signed [63:0] mp [12];
    logic signed [snp_pkg::DW-1:0] m [6];
  } pipe_t;

  function automatic sq_t sq_step(input logic [127:0] x, input logic [127:0] res,
                                  input logic [127:0] bv);
    sq_t o;
    logic [127:0] t;
    t = res + bv;
    if (x >= t) begin
      o.x = x - t;
      o.res = (res >> 1) + bv;
    end else begin
      o.x = x;
      o.res = res >> 1;
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input logic [34:0] rem, input logic [29:0] q,
                                  input logic [33:0] den);
    dv_t o;
    logic [34:0] r2;
    r2 = {rem[33:0], 1'b0};
    if (r2 >= 35'(den)) begin
      o.rem = r2 - 35'(den);
      o.q = {q[28:0], 1'b1};
    end else begin
      o.rem = r2;
      o.q = {q[28:0], 1'b0};
    end
    return o;
  endfunction

  function automatic logic signed [65:0] rnd(input logic signed [65:0] v,
                                             input int unsigned n);
    logic [65:0] mg;
    mg = v[65] ? 66'(-v) : 66'(v);
    mg = (mg + (66'(1) << (n - 1))) >> n;
    return v[65] ? -$signed(mg) : $signed(mg);
  endfunction

  function automatic logic signed [snp_pkg::DW-1:0] sat(input logic signed [65:0] v);
    logic signed [65:0] hi;
    logic signed [65:0] lo;
    hi = 66'sd2147483647;
    lo = -66'sd2147483648;
    if (v > hi) return snp_pkg::DW'(hi);
    if (v < lo) return snp_pkg::DW'(lo);
    return snp_pkg::DW'(v);
  endfunction

  logic [snp_pkg::SW-1:0] thr;
  logic [NST-1:0] vld;
  logic en;
  pipe_t st [NST];

  assign en = !vld[NST-1] || dst.ready;
  assign src.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= snp_pkg::THR_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], src.valid};
    end
  end

  for (genvar gi = 0; gi < NST; gi++) begin : g_st
    pipe_t nx;

    if (gi == S_IN) begin : g_in
      always_comb begin
        nx = st[0];
        nx.a[0] = src.q_r0c0;
        nx.a[1] = src.q_r0c1;
        nx.a[2] = src.q_r0c2;
        nx.a[3] = src.q_r1c0;
        nx.a[4] = src.q_r1c1;
        nx.a[5] = src.q_r1c2;
      end
    end else begin : g_wk
      always_comb begin
        sq_t sq;
        dv_t dv;
        logic [2:0] grp;
        logic [2:0] bb;
        logic [7:0] byt;
        logic [5:0] msb;
        logic [64:0] twoh;
        logic [65:0] l1;
        logic [64:0] l2;
        logic [63:0] sh;
        logic [34:0] sum;
        logic [30:0] cq;
        logic [30:0] sqv;
        logic [30:0] t1;
        logic [30:0] t2;
        logic signed [31:0] dt;
        nx = st[gi-1];
        sq = '0;
        dv = '0;
        grp = '0;
        bb = '0;
        byt = '0;
        msb = '0;
        twoh = '0;
        l1 = '0;
        l2 = '0;
        sh = '0;
        sum = '0;
        cq = '0;
        sqv = '0;
        t1 = '0;
        t2 = '0;
        dt = '0;
        if (gi == S_PROD) begin
          for (int i = 0; i < 3; i++) begin
            nx.pr[i] = nx.a[i] * nx.a[i];
            nx.pr[3+i] = nx.a[3+i] * nx.a[3+i];
            nx.pr[6+i] = nx.a[i] * nx.a[3+i];
          end
        end
        if (gi == S_SUM) begin
          nx.p = $unsigned(nx.pr[0]) + $unsigned(nx.pr[1]) + $unsigned(nx.pr[2]);
          nx.q = $unsigned(nx.pr[3]) + $unsigned(nx.pr[4]) + $unsigned(nx.pr[5]);
          nx.r = 66'(nx.pr[6]) + 66'(nx.pr[7]) + 66'(nx.pr[8]);
        end
        if (gi == S_ABS) begin
          nx.e_neg = nx.p < nx.q;
          nx.emag = nx.e_neg ? nx.q - nx.p : nx.p - nx.q;
          nx.r_neg = nx.r < 0;
          nx.rmag = nx.r_neg ? 64'(-nx.r) : 64'(nx.r);
          nx.tr = 65'(nx.p) + 65'(nx.q);
        end
        if (gi == S_PART) begin
          nx.pe[0] = nx.emag[31:0] * nx.emag[31:0];
          nx.pe[1] = nx.emag[31:0] * nx.emag[63:32];
          nx.pe[2] = nx.emag[63:32] * nx.emag[63:32];
          nx.rp[0] = nx.rmag[31:0] * nx.rmag[31:0];
          nx.rp[1] = nx.rmag[31:0] * nx.rmag[63:32];
          nx.rp[2] = nx.rmag[63:32] * nx.rmag[63:32];
        end
        if (gi == S_SQ) begin
          nx.e2 = {nx.pe[2], 64'b0} + {31'b0, nx.pe[1], 33'b0} + 128'(nx.pe[0]);
          nx.r2 = {nx.rp[2], 64'b0} + {31'b0, nx.rp[1], 33'b0} + 128'(nx.rp[0]);
        end
        if (gi == S_D4) begin
          nx.x = (nx.e2 >> 2) + nx.r2;
          nx.res = '0;
        end
        if (gi >= S_H0 && gi < S_L) begin
          sq = sq_step(nx.x, nx.res, 128'(1) << (126 - 2 * (gi - S_H0)));
          nx.x = sq.x;
          nx.res = sq.res;
        end
        if (gi == S_L) begin
          nx.h = nx.res[63:0];
          twoh = {nx.h, 1'b0};
          l1 = 66'(nx.tr) + 66'(twoh);
          l2 = (nx.tr >= twoh) ? nx.tr - twoh : '0;
          nx.x1 = 68'(l1[65:1]);
          nx.x2 = 68'(l2[64:1]);
          nx.res1 = '0;
          nx.res2 = '0;
          for (int g = 0; g < 8; g++) begin
            nx.nz[g] = |nx.h[8*g +: 8];
          end
        end
        if (gi >= S_N0 && gi < S_SHR) begin
          sq = sq_step(128'(nx.x1), 128'(nx.res1), 128'(1) << (66 - 2 * (gi - S_N0)));
          nx.x1 = sq.x[67:0];
          nx.res1 = sq.res[67:0];
          sq = sq_step(128'(nx.x2), 128'(nx.res2), 128'(1) << (66 - 2 * (gi - S_N0)));
          nx.x2 = sq.x[67:0];
          nx.res2 = sq.res[67:0];
          if (gi == S_N0) begin
            for (int g = 0; g < 8; g++) begin
              if (nx.nz[g]) grp = 3'(g);
            end
            byt = nx.h[8*grp +: 8];
            for (int b = 0; b < 8; b++) begin
              if (byt[b]) bb = 3'(b);
            end
            msb = {grp, bb};
            nx.k = (msb >= 6'd31) ? msb - 6'd30 : 6'd0;
          end
          if (gi == S_N0 + 1) begin
            sh = nx.h >> nx.k;
            nx.hs = (sh == '0) ? 31'd1 : sh[30:0];
            sh = nx.emag >> (7'(nx.k) + 7'd1);
            nx.es = (sh > 64'h8000_0000) ? 32'h8000_0000 : sh[31:0];
            sh = nx.rmag >> nx.k;
            nx.rs = (sh > 64'h8000_0000) ? 32'h8000_0000 : sh[31:0];
          end
          if (gi == S_N0 + 2) begin
            nx.fc = nx.es >= 32'(nx.hs);
            nx.fs = nx.rs >= 32'(nx.hs);
            nx.remc = 33'(nx.es);
            nx.rems = 33'(nx.rs);
            nx.qc = '0;
            nx.qs = '0;
          end
          if (gi >= S_N0 + 3 && gi < S_N0 + 3 + NQ) begin
            dv = dv_step(35'(nx.remc), nx.qc, 34'(nx.hs));
            nx.remc = dv.rem[32:0];
            nx.qc = dv.q;
            dv = dv_step(35'(nx.rems), nx.qs, 34'(nx.hs));
            nx.rems = dv.rem[32:0];
            nx.qs = dv.q;
          end
          if (gi == S_SHR - 1) begin
            cq = nx.fc ? snp_pkg::ONE30 : {1'b0, nx.qc};
            sqv = nx.fs ? snp_pkg::ONE30 : {1'b0, nx.qs};
            if (nx.rmag == '0) begin
              nx.p00 = nx.e_neg ? 33'sd0 : 33'sh0_8000_0000;
              nx.p01 = 33'sd0;
            end else begin
              nx.p00 = nx.e_neg ? $signed(33'(snp_pkg::ONE30) - 33'(cq))
                                : $signed(33'(snp_pkg::ONE30) + 33'(cq));
              nx.p01 = nx.r_neg ? -$signed(33'(sqv)) : $signed(33'(sqv));
            end
            nx.p11 = 33'sh0_8000_0000 - nx.p00;
          end
        end
        if (gi == S_SHR) begin
          nx.s1 = nx.res1[33:0];
          nx.s2 = nx.res2[33:0];
          sum = 35'(nx.s1) + 35'(nx.s2);
          if (sum <= 35'(thr)) begin
            nx.n1 = '0;
            nx.n2 = '0;
          end else if ((nx.s1 - nx.s2) <= 34'(thr)) begin
            nx.n1 = 34'((sum - 35'(thr)) >> 1);
            nx.n2 = nx.n1;
          end else begin
            nx.n1 = nx.s1 - 34'(thr);
            nx.n2 = nx.s2;
          end
          nx.degen = (nx.s1 == '0) || (nx.s2 == '0);
          nx.ts = (nx.n1 > 34'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : nx.n1[30:0];
        end
        if (gi == S_TI) begin
          nx.z1 = nx.s1 == '0;
          nx.z2 = nx.s2 == '0;
          nx.f1 = nx.n1 >= nx.s1;
          nx.f2 = nx.n2 >= nx.s2;
          nx.rem1 = 35'(nx.n1);
          nx.rem2 = 35'(nx.n2);
          nx.q1 = '0;
          nx.q2 = '0;
        end
        if (gi >= S_T0 && gi < S_MW) begin
          dv = dv_step(nx.rem1, nx.q1, nx.s1);
          nx.rem1 = dv.rem;
          nx.q1 = dv.q;
          dv = dv_step(nx.rem2, nx.q2, nx.s2);
          nx.rem2 = dv.rem;
          nx.q2 = dv.q;
        end
        if (gi == S_MW) begin
          t1 = nx.z1 ? 31'd0 : (nx.f1 ? snp_pkg::ONE30 : {1'b0, nx.q1});
          t2 = nx.z2 ? 31'd0 : (nx.f2 ? snp_pkg::ONE30 : {1'b0, nx.q2});
          dt = $signed({1'b0, t1}) - $signed({1'b0, t2});
          nx.base = $signed({2'b0, t2, 31'b0});
          nx.pw[0] = dt * nx.p00;
          nx.pw[1] = dt * nx.p01;
          nx.pw[2] = dt * nx.p11;
        end
        if (gi == S_W) begin
          nx.w00 = 32'(rnd(66'(nx.base) + nx.pw[0], 31));
          nx.w01 = 32'(rnd(nx.pw[1], 31));
          nx.w11 = 32'(rnd(66'(nx.base) + nx.pw[2], 31));
        end
        if (gi == S_MM) begin
          for (int c = 0; c < 3; c++) begin
            nx.mp[c] = nx.w00 * nx.a[c];
            nx.mp[3+c] = nx.w01 * nx.a[3+c];
            nx.mp[6+c] = nx.w01 * nx.a[c];
            nx.mp[9+c] = nx.w11 * nx.a[3+c];
          end
        end
        if (gi == S_OUT) begin
          for (int c = 0; c < 3; c++) begin
            nx.m[c] = sat(rnd(66'(nx.mp[c]) + 66'(nx.mp[3+c]), 30));
            nx.m[3+c] = sat(rnd(66'(nx.mp[6+c]) + 66'(nx.mp[9+c]), 30));
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        st[gi] <= nx;
      end
    end
  end

  assign dst.valid = vld[NST-1];
  assign dst.m_r0c0 = st[NST-1].m[0];
  assign dst.m_r0c1 = st[NST-1].m[1];
  assign dst.m_r0c2 = st[NST-1].m[2];
  assign dst.m_r1c0 = st[NST-1].m[3];
  assign dst.m_r1c1 = st[NST-1].m[4];
  assign dst.m_r1c2 = st[NST-1].m[5];
  assign dst.top_sigma = st[NST-1].ts;
  assign dst.degenerate = st[NST-1].degen;

`ifndef ASSERT_OFF
  a_reset_empty: assert property (@(posedge clk) rst |=> !dst.valid)
    else $error("output valid right after reset");
  a_sigma_order: assert property (@(posedge clk) disable iff (rst)
    vld[S_SHR] |-> st[S_SHR].s1 >= st[S_SHR].s2)
    else $error("singular values out of order");
  a_advance: assert property (@(posedge clk) disable iff (rst)
    en && vld[NST-2] |=> dst.valid)
    else $error("beat lost before the output stage");
`endif

endmodule
`default_nettype wire

// ===== bench/snp_checker.sv =====
// Checker that predicts and compares the output beats of the singular value shrink block.
`timescale 1ns / 100ps
module snp_checker (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire logic [snp_pkg::SW-1:0] cfg_wdata,
  snp_in_if                           src,
  snp_out_if                          dst,
  output int                          errors,
  output int                          pending
);
  typedef struct {
    logic [snp_pkg::DW-1:0] m [6];
    logic [snp_pkg::SW-1:0] top_sigma;
    logic                   degenerate;
  } shrunk_t;

  shrunk_t                shrunk_q [$];
  logic [snp_pkg::SW-1:0] thr_mirror;
  int                     beats_seen;

  function automatic longint unsigned isqrt128(logic [127:0] x);
    longint unsigned r;
    longint unsigned c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (x >= {64'd0, c} * {64'd0, c}) r = c;
    end
    return r;
  endfunction

  function automatic longint unsigned ratio_q30(longint unsigned num, longint unsigned den);
    longint unsigned t;
    if (den == 0) return 0;
    t = (num << 30) / den;
    return (t > 64'd1073741824) ? 64'd1073741824 : t;
  endfunction

  function automatic longint round_half(longint x, int n);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = (m + (64'd1 << (n - 1))) >> n;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic shrunk_t predict_shrink(logic [snp_pkg::DW-1:0] q [6],
                                              logic [snp_pkg::SW-1:0] thr);
    shrunk_t         res;
    longint          a [6];
    longint unsigned mag [6];
    bit              neg [6];
    longint unsigned pp, qq, rpos, rneg, rmag, emag, h, s1, s2, n1, n2, t1, t2, thr64;
    longint unsigned hs, es, rs, cq, sq;
    bit              r_neg, e_neg;
    logic [127:0]    d4, tr, twoh, l1, l2;
    longint          p00, p01, p11, dt, base, v;
    longint          w [2][2];
    int              k;
    pp = 0; qq = 0; rpos = 0; rneg = 0;
    thr64 = {33'd0, thr};
    for (int i = 0; i < 6; i++) begin
      a[i] = longint'($signed(q[i]));
      neg[i] = a[i] < 0;
      mag[i] = neg[i] ? -a[i] : a[i];
    end
    for (int i = 0; i < 3; i++) begin
      pp += mag[i] * mag[i];
      qq += mag[i+3] * mag[i+3];
      if (neg[i] != neg[i+3]) rneg += mag[i] * mag[i+3];
      else rpos += mag[i] * mag[i+3];
    end
    r_neg = rneg > rpos;
    rmag = r_neg ? rneg - rpos : rpos - rneg;
    e_neg = pp < qq;
    emag = e_neg ? qq - pp : pp - qq;
    d4 = (({64'd0, emag} * {64'd0, emag}) >> 2) + {64'd0, rmag} * {64'd0, rmag};
    h = isqrt128(d4);
    tr = {64'd0, pp} + {64'd0, qq};
    twoh = {64'd0, h} << 1;
    l1 = tr + twoh;
    l2 = (tr >= twoh) ? tr - twoh : 128'd0;
    s1 = isqrt128(l1 >> 1);
    s2 = isqrt128(l2 >> 1);
    if (s1 + s2 <= thr64) begin
      n1 = 0; n2 = 0;
    end else if (s1 - s2 <= thr64) begin
      n1 = (s1 + s2 - thr64) >> 1; n2 = n1;
    end else begin
      n1 = s1 - thr64; n2 = s2;
    end
    t1 = ratio_q30(n1, s1);
    t2 = ratio_q30(n2, s2);
    if (rmag == 0) begin
      p00 = e_neg ? 0 : 64'sd2147483648;
      p01 = 0;
    end else begin
      k = 0;
      while ((h >> k) >= 64'h8000_0000) k++;
      hs = h >> k;
      if (hs == 0) hs = 1;
      es = emag >> (k + 1);
      rs = rmag >> k;
      if (es > 64'h8000_0000) es = 64'h8000_0000;
      if (rs > 64'h8000_0000) rs = 64'h8000_0000;
      cq = (es << 30) / hs;
      if (cq > 64'h4000_0000) cq = 64'h4000_0000;
      sq = (rs << 30) / hs;
      if (sq > 64'h4000_0000) sq = 64'h4000_0000;
      p00 = e_neg ? longint'(64'h4000_0000 - cq) : longint'(64'h4000_0000 + cq);
      p01 = r_neg ? -longint'(sq) : longint'(sq);
    end
    p11 = 64'sd2147483648 - p00;
    dt = longint'(t1) - longint'(t2);
    base = longint'(t2 << 31);
    w[0][0] = round_half(base + dt * p00, 31);
    w[0][1] = round_half(dt * p01, 31);
    w[1][0] = w[0][1];
    w[1][1] = round_half(base + dt * p11, 31);
    for (int r = 0; r < 2; r++)
      for (int c = 0; c < 3; c++) begin
        v = round_half(w[r][0] * a[c] + w[r][1] * a[3+c], 30);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        res.m[r*3+c] = v[31:0];
      end
    res.top_sigma = (n1 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : n1[30:0];
    res.degenerate = (s1 == 0 || s2 == 0);
    return res;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH beat %0d %s: got %h expected %h", beats_seen, what, got, want);
  endtask

  assign pending = shrunk_q.size();

  initial errors = 0;

  always @(posedge clk) begin
    logic [snp_pkg::DW-1:0] q [6];
    shrunk_t got, want;
    if (rst) begin
      thr_mirror <= snp_pkg::THR_RESET;
      beats_seen <= 0;
    end else begin
      if (cfg_we) thr_mirror <= cfg_wdata;
      if (src.valid && src.ready) begin
        q[0] = src.q_r0c0; q[1] = src.q_r0c1; q[2] = src.q_r0c2;
        q[3] = src.q_r1c0; q[4] = src.q_r1c1; q[5] = src.q_r1c2;
        shrunk_q.push_back(predict_shrink(q, thr_mirror));
      end
      if (dst.valid && dst.ready) begin
        beats_seen <= beats_seen + 1;
        got.m[0] = dst.m_r0c0; got.m[1] = dst.m_r0c1; got.m[2] = dst.m_r0c2;
        got.m[3] = dst.m_r1c0; got.m[4] = dst.m_r1c1; got.m[5] = dst.m_r1c2;
        if (shrunk_q.size() == 0) begin
          report("unexpected beat", 32'd0, 32'd0);
        end else begin
          want = shrunk_q.pop_front();
          for (int i = 0; i < 6; i++)
            if (got.m[i] !== want.m[i]) report($sformatf("m[%0d]", i), got.m[i], want.m[i]);
          if (dst.top_sigma !== want.top_sigma)
            report("top_sigma", {1'b0, dst.top_sigma}, {1'b0, want.top_sigma});
          if (dst.degenerate !== want.degenerate)
            report("degenerate", {31'd0, dst.degenerate}, {31'd0, want.degenerate});
        end
      end
    end
  end
endmodule

// ===== bench/tb_top.sv =====
// Top of the testbench: clock, reset, matrix stimulus, threshold writes and the verdict.
`timescale 1ns / 100ps
module tb_top;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;

  logic                   clk;
  logic                   rst;
  logic                   cfg_we;
  logic [snp_pkg::SW-1:0] cfg_wdata;
  int                     errors;
  int                     pending;
  int                     idle_cycles;
  int                     matrices_sent;
  int                     thr_writes;
  bit                     no_idle;

  snp_in_if  src_ch ();
  snp_out_if dst_ch ();

  spectral_norm_prox_2x3 u_dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .src(src_ch), .dst(dst_ch)
  );

  snp_checker u_checker (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .src(src_ch), .dst(dst_ch), .errors(errors), .pending(pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (src_ch.valid && src_ch.ready) || (dst_ch.valid && dst_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired with %0d results outstanding", pending);
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int stall;
    dst_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        dst_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      dst_ch.ready <= 1'b1;
      do @(posedge clk); while (!dst_ch.valid);
    end
  end

  task automatic send_matrix(logic [31:0] q [6]);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      src_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_ch.valid <= 1'b1;
    src_ch.q_r0c0 <= q[0]; src_ch.q_r0c1 <= q[1]; src_ch.q_r0c2 <= q[2];
    src_ch.q_r1c0 <= q[3]; src_ch.q_r1c1 <= q[4]; src_ch.q_r1c2 <= q[5];
    do @(posedge clk); while (!src_ch.ready);
    matrices_sent++;
  endtask

  task automatic write_threshold(logic [snp_pkg::SW-1:0] value);
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    thr_writes++;
  endtask

  function automatic logic [31:0] entry_of(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
      2: return $signed($urandom_range(0, 1 << 25)) - (1 << 24);
      default: return 32'd0;
    endcase
  endfunction

  task automatic random_matrix(output logic [31:0] q [6]);
    int mode, shape;
    mode = $urandom_range(0, 2);
    shape = $urandom_range(0, 9);
    for (int i = 0; i < 6; i++) q[i] = entry_of(mode);
    case (shape)
      0: for (int i = 0; i < 3; i++) q[i+3] = q[i];
      1: for (int i = 0; i < 3; i++) q[i+3] = -q[i];
      2: begin
        q[1] = 0; q[2] = 0; q[3] = 0;
      end
      3: for (int i = 0; i < 3; i++) q[i+3] = 0;
      4: for (int i = 0; i < 6; i++) q[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      5: begin
        q[0] = entry_of(mode); q[1] = 0; q[2] = 0;
        q[3] = 0; q[4] = q[0]; q[5] = 0;
      end
      default: ;
    endcase
  endtask

  task automatic directed_matrices();
    logic [31:0] q [6];
    logic [31:0] one;
    one = 32'h0001_0000;
    q = '{default: 32'd0};                                             send_matrix(q);
    q = '{default: 32'h7FFF_FFFF};                                     send_matrix(q);
    q = '{default: 32'h8000_0000};                                     send_matrix(q);
    q = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};                send_matrix(q);
    q = '{one, 0, 0, 0, one, 0};                                       send_matrix(q);
    q = '{3*one, 0, 0, 0, 2*one, 0};                                   send_matrix(q);
    q = '{one, 0, 0, 0, 5*one, 0};                                     send_matrix(q);
    q = '{2*one, one, 0, 2*one, one, 0};                               send_matrix(q);
    q = '{2*one, one, 0, -2*one, -one, 0};                             send_matrix(q);
    q = '{4*one, one, 0, one, 3*one, 2*one};                           send_matrix(q);
    q = '{4*one, one, 0, -one, -3*one, 2*one};                         send_matrix(q);
    q = '{one, one, one, one, -one, 0};                                send_matrix(q);
    q = '{one, 0, 0, 0, 0, 0};                                         send_matrix(q);
    q = '{0, 0, 0, 0, 0, 32'h0000_0001};                               send_matrix(q);
    q = '{32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 32'hFFFF_FFFF};        send_matrix(q);
    q = '{10*one, 0, 0, 0, 32'h0001_8000, 0};                          send_matrix(q);
    q = '{32'h0001_8000, 32'h0000_8000, 0, 32'h0000_8000, 32'h0001_8000, 0};
    send_matrix(q);
  endtask

  initial begin
    logic [31:0] q [6];
    logic [snp_pkg::SW-1:0] thr_list [6];
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    no_idle = 1'b0;
    matrices_sent = 0;
    thr_writes = 0;
    idle_cycles = 0;
    src_ch.valid = 1'b0;
    src_ch.q_r0c0 = '0; src_ch.q_r0c1 = '0; src_ch.q_r0c2 = '0;
    src_ch.q_r1c0 = '0; src_ch.q_r1c1 = '0; src_ch.q_r1c2 = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    directed_matrices();
    thr_list = '{31'd0, 31'h7FFF_FFFF, 31'd65536, 31'd1,
                 31'($urandom()), 31'($urandom_range(0, 1 << 22))};
    for (int phase = 0; phase < 7; phase++) begin
      if (phase > 0) write_threshold(thr_list[phase-1]);
      for (int n = 0; n < 220; n++) begin
        if (n % 60 == 0) no_idle = ($urandom_range(0, 3) == 0);
        random_matrix(q);
        send_matrix(q);
      end
    end
    no_idle = 1'b0;
    src_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d matrices over %0d threshold settings, including zero and full scale.",
             matrices_sent, thr_writes + 1);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", errors);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
